>>> hw/rtl/sbsmi_pkg.sv
// sbsmi_pkg: shared types, register offsets and the irq routing table
// for the southbridge config space with smi trap port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sbsmi_pkg;

	// bus access codes
	typedef enum logic [1:0] {
		MODE_CFG_RD  = 2'd0,
		MODE_CFG_WR  = 2'd1,
		MODE_TRAP_RD = 2'd2,
		MODE_TRAP_WR = 2'd3
	} mode_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_CHIP_VARIANT   = 2'd0,
		CFG_SPEED_READOUT  = 2'd1,
		CFG_FAST_BUS       = 2'd2,
		CFG_LOW_MULTIPLIER = 2'd3
	} cfg_idx_t;

	localparam int BYTE_W     = 8;
	localparam int FUNC_W     = 3;
	localparam int IO_W       = 16;
	localparam int IRQ_W      = 4;
	localparam int NUM_INT    = 4;
	localparam int BANK5_AW   = 4;   // offsets 0x50..0x5f
	localparam int BANK6_AW   = 5;   // offsets 0x60..0x7f
	localparam int BANK5_DEPTH = 1 << BANK5_AW;
	localparam int BANK6_DEPTH = 1 << BANK6_AW;

	// fixed identity bytes
	localparam logic [7:0] VENDOR_LO   = 8'h04;
	localparam logic [7:0] VENDOR_HI   = 8'h10;
	localparam logic [7:0] DEV_ID_A    = 8'h06;
	localparam logic [7:0] DEV_ID_B    = 8'h08;
	localparam logic [7:0] SUBCLASS    = 8'h01;
	localparam logic [7:0] BASECLASS   = 8'h06;

	// register offsets
	localparam logic [7:0] REG_VENDOR_LO = 8'h00;
	localparam logic [7:0] REG_VENDOR_HI = 8'h01;
	localparam logic [7:0] REG_DEV_ID    = 8'h02;
	localparam logic [7:0] REG_SUBCLASS  = 8'h0A;
	localparam logic [7:0] REG_BASECLASS = 8'h0B;
	localparam logic [7:0] REG_CMD_LO    = 8'h04;
	localparam logic [7:0] REG_CMD_HI    = 8'h05;
	localparam logic [7:0] REG_SMI_STAT  = 8'h69;
	localparam logic [7:0] REG_NIBBLE    = 8'h6A;
	localparam logic [7:0] REG_ROUTE_AB  = 8'h74;
	localparam logic [7:0] REG_ROUTE_CD  = 8'h75;

	// bank 6 slots read at fixed places
	localparam logic [BANK6_AW-1:0] B6_SMI_EN     = 5'h00;  // 0x60
	localparam logic [BANK6_AW-1:0] B6_SMI_STAT   = 5'h01;  // 0x61
	localparam logic [BANK6_AW-1:0] B6_PORT_HI    = 5'h02;  // 0x62
	localparam logic [BANK6_AW-1:0] B6_PORT_LO    = 5'h03;  // 0x63
	localparam logic [BANK6_AW-1:0] B6_GLOBAL_EN  = 5'h0D;  // 0x6d
	localparam logic [BANK6_AW-1:0] B6_JUMPER_SEL = 5'h13;  // 0x73

	localparam logic [7:0] SMI_STAT_SET   = 8'h80;
	localparam logic [7:0] NIBBLE_MASK    = 8'h0F;
	localparam logic [7:0] JUMPER_MASK    = 8'h2A;
	localparam logic [7:0] BYTE_ONES      = 8'hFF;
	localparam int         EN_BIT         = 7;

	// 3-bit route code to isa irq number
	function automatic logic [IRQ_W-1:0] irq_lookup(input logic [2:0] code);
		logic [IRQ_W-1:0] irq;
		case (code)
			3'd0:    irq = 4'd3;
			3'd1:    irq = 4'd5;
			3'd2:    irq = 4'd9;
			3'd3:    irq = 4'd10;
			3'd4:    irq = 4'd11;
			3'd5:    irq = 4'd12;
			3'd6:    irq = 4'd14;
			default: irq = 4'd15;
		endcase
		return irq;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/southbridge_smi_trap_regs_top.sv
// southbridge_smi_trap_regs_top: pci config space of function 0 with an
// smi trap port and pci interrupt routing; depends on sbsmi_pkg
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake           payload
// in        in         in_valid/in_stall   mode, function_number, reg_addr,
//                                          io_addr, data
// out       out        out_valid/out_stall read_data, trap_hit, smi_request,
//                                          inta_irq..intd_irq
// cfg       in         cfg_wen             cfg_idx, cfg_data
//
// every request passes the input register, where the register file is read
// and decoded, and then the result register. one request is accepted per
// cycle while the result side does not stall; the register file is updated at
// the same edge the request moves into the result register, so the next request
// sees its effect. a stalled result holds the input register; an empty input
// register still takes one more request and then stalls the input side.
// reset clears the register file, the trap latch and routing to zero.
module southbridge_smi_trap_regs_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        cfg_wen,
	input  wire logic [1:0]                  cfg_idx,
	input  wire logic                        cfg_data,
	// request channel
	input  wire logic                        in_valid,
	output      logic                        in_stall,
	input  wire logic [1:0]                  mode,
	input  wire logic [sbsmi_pkg::FUNC_W-1:0] function_number,
	input  wire logic [sbsmi_pkg::BYTE_W-1:0] reg_addr,
	input  wire logic [sbsmi_pkg::IO_W-1:0]   io_addr,
	input  wire logic [sbsmi_pkg::BYTE_W-1:0] data,
	// result channel
	output      logic                        out_valid,
	input  wire logic                        out_stall,
	output      logic [sbsmi_pkg::BYTE_W-1:0] read_data,
	output      logic                        trap_hit,
	output      logic                        smi_request,
	output      logic [sbsmi_pkg::IRQ_W-1:0]  inta_irq,
	output      logic [sbsmi_pkg::IRQ_W-1:0]  intb_irq,
	output      logic [sbsmi_pkg::IRQ_W-1:0]  intc_irq,
	output      logic [sbsmi_pkg::IRQ_W-1:0]  intd_irq
);

	// configuration registers
	logic chip_variant_q, speed_readout_q, fast_bus_q, low_mult_q;

	// writable part of config space; everything else is constant
	logic [sbsmi_pkg::BYTE_W-1:0] cmd_q [2];
	logic [sbsmi_pkg::BYTE_W-1:0] bank5_q [sbsmi_pkg::BANK5_DEPTH];
	logic [sbsmi_pkg::BYTE_W-1:0] bank6_q [sbsmi_pkg::BANK6_DEPTH];
	logic [sbsmi_pkg::BYTE_W-1:0] trap_latch_q;
	logic [sbsmi_pkg::IRQ_W-1:0]  route_q [sbsmi_pkg::NUM_INT];

	// input register
	logic                         valid_s1;
	sbsmi_pkg::mode_t             mode_s1;
	logic [sbsmi_pkg::FUNC_W-1:0] func_s1;
	logic [sbsmi_pkg::BYTE_W-1:0] reg_s1;
	logic [sbsmi_pkg::IO_W-1:0]   io_s1;
	logic [sbsmi_pkg::BYTE_W-1:0] data_s1;

	// result register
	logic                         out_valid_q;
	logic [sbsmi_pkg::BYTE_W-1:0] read_data_q;
	logic                         trap_hit_q;
	logic                         smi_q;
	logic [sbsmi_pkg::IRQ_W-1:0]  irq_q [sbsmi_pkg::NUM_INT];

	// datapath
	logic                         advance;
	logic                         fire_s1;
	logic [sbsmi_pkg::IO_W-1:0]   trap_port;
	logic                         port_match;
	logic                         smi_enabled;
	logic [sbsmi_pkg::BYTE_W-1:0] cfg_rd;
	logic                         func_zero;
	logic                         wr_cmd, wr_b5, wr_b6;
	logic [sbsmi_pkg::BYTE_W-1:0] wr_val;
	logic                         trap_set;
	logic [sbsmi_pkg::BYTE_W-1:0] rd_next;
	logic                         hit_next;
	logic [sbsmi_pkg::IRQ_W-1:0]  route_next [sbsmi_pkg::NUM_INT];

	// handshake: the input register moves on whenever the result slot is free
	assign advance  = !out_valid_q || !out_stall;
	assign fire_s1  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// trap port match and smi enables
	assign trap_port   = {bank6_q[sbsmi_pkg::B6_PORT_HI], bank6_q[sbsmi_pkg::B6_PORT_LO]};
	assign port_match  = (trap_port != '0) && (io_s1 == trap_port);
	assign smi_enabled = bank6_q[sbsmi_pkg::B6_GLOBAL_EN][sbsmi_pkg::EN_BIT] &&
		bank6_q[sbsmi_pkg::B6_SMI_EN][sbsmi_pkg::EN_BIT];
	assign func_zero   = (func_s1 == '0);

	// config read decode
	always_comb begin
		case (reg_s1) inside
			sbsmi_pkg::REG_VENDOR_LO: cfg_rd = sbsmi_pkg::VENDOR_LO;
			sbsmi_pkg::REG_VENDOR_HI: cfg_rd = sbsmi_pkg::VENDOR_HI;
			sbsmi_pkg::REG_DEV_ID:
				cfg_rd = chip_variant_q ? sbsmi_pkg::DEV_ID_B : sbsmi_pkg::DEV_ID_A;
			sbsmi_pkg::REG_SUBCLASS:  cfg_rd = sbsmi_pkg::SUBCLASS;
			sbsmi_pkg::REG_BASECLASS: cfg_rd = sbsmi_pkg::BASECLASS;
			sbsmi_pkg::REG_CMD_LO, sbsmi_pkg::REG_CMD_HI: cfg_rd = cmd_q[reg_s1[0]];
			[8'h50:8'h5F]: cfg_rd = bank5_q[reg_s1[sbsmi_pkg::BANK5_AW-1:0]];
			[8'h60:8'h7F]: cfg_rd = bank6_q[reg_s1[sbsmi_pkg::BANK6_AW-1:0]];
			default:       cfg_rd = '0;
		endcase
		// speed jumper readout merged into the smi status byte
		if (reg_s1 == sbsmi_pkg::REG_SMI_STAT && speed_readout_q &&
				(bank6_q[sbsmi_pkg::B6_JUMPER_SEL] & sbsmi_pkg::JUMPER_MASK) != '0) begin
			cfg_rd = {cfg_rd[7:3], 1'b1, fast_bus_q, low_mult_q};
		end
	end

	// config write decode: which bank, and the byte that lands there
	always_comb begin
		wr_cmd = 1'b0;
		wr_b5  = 1'b0;
		wr_b6  = 1'b0;
		wr_val = data_s1;
		case (reg_s1) inside
			sbsmi_pkg::REG_CMD_LO, sbsmi_pkg::REG_CMD_HI: wr_cmd = 1'b1;
			[8'h50:8'h5A], [8'h5C:8'h5D]: wr_b5 = 1'b1;
			8'h60, [8'h62:8'h64], 8'h66, 8'h68, [8'h6B:8'h78]: wr_b6 = 1'b1;
			// status bytes clear on any write
			8'h61, 8'h65, 8'h67, sbsmi_pkg::REG_SMI_STAT: begin
				wr_b6  = 1'b1;
				wr_val = '0;
			end
			sbsmi_pkg::REG_NIBBLE: begin
				wr_b6  = 1'b1;
				wr_val = data_s1 & sbsmi_pkg::NIBBLE_MASK;
			end
			default: ;
		endcase
		if (!(mode_s1 == sbsmi_pkg::MODE_CFG_WR && func_zero)) begin
			wr_cmd = 1'b0;
			wr_b5  = 1'b0;
			wr_b6  = 1'b0;
		end
	end

	// per-request result
	always_comb begin
		rd_next  = '0;
		hit_next = 1'b0;
		trap_set = 1'b0;
		unique case (mode_s1)
			sbsmi_pkg::MODE_CFG_RD: rd_next = func_zero ? cfg_rd : sbsmi_pkg::BYTE_ONES;
			sbsmi_pkg::MODE_CFG_WR: ;
			sbsmi_pkg::MODE_TRAP_RD: begin
				hit_next = port_match;
				rd_next  = port_match ? trap_latch_q : sbsmi_pkg::BYTE_ONES;
			end
			sbsmi_pkg::MODE_TRAP_WR: begin
				hit_next = port_match;
				trap_set = port_match && smi_enabled;
			end
			default: ;
		endcase
	end

	// interrupt routing after this request
	always_comb begin
		for (int i = 0; i < sbsmi_pkg::NUM_INT; i++) begin
			route_next[i] = route_q[i];
		end
		if (wr_b6 && reg_s1 == sbsmi_pkg::REG_ROUTE_AB) begin
			route_next[0] = sbsmi_pkg::irq_lookup(data_s1[2:0]);
			route_next[1] = sbsmi_pkg::irq_lookup(data_s1[6:4]);
		end else if (wr_b6 && reg_s1 == sbsmi_pkg::REG_ROUTE_CD) begin
			route_next[2] = sbsmi_pkg::irq_lookup(data_s1[2:0]);
			route_next[3] = sbsmi_pkg::irq_lookup(data_s1[6:4]);
		end
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_variant_q  <= 1'b0;
			speed_readout_q <= 1'b0;
			fast_bus_q      <= 1'b0;
			low_mult_q      <= 1'b0;
		end else if (cfg_wen) begin
			unique case (sbsmi_pkg::cfg_idx_t'(cfg_idx))
				sbsmi_pkg::CFG_CHIP_VARIANT:   chip_variant_q  <= cfg_data;
				sbsmi_pkg::CFG_SPEED_READOUT:  speed_readout_q <= cfg_data;
				sbsmi_pkg::CFG_FAST_BUS:       fast_bus_q      <= cfg_data;
				sbsmi_pkg::CFG_LOW_MULTIPLIER: low_mult_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// register file, trap latch and routing update as the request retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) cmd_q[i] <= '0;
			for (int i = 0; i < sbsmi_pkg::BANK5_DEPTH; i++) bank5_q[i] <= '0;
			for (int i = 0; i < sbsmi_pkg::BANK6_DEPTH; i++) bank6_q[i] <= '0;
			for (int i = 0; i < sbsmi_pkg::NUM_INT; i++) route_q[i] <= '0;
			trap_latch_q <= '0;
		end else if (fire_s1) begin
			if (wr_cmd) cmd_q[reg_s1[0]] <= wr_val;
			if (wr_b5) bank5_q[reg_s1[sbsmi_pkg::BANK5_AW-1:0]] <= wr_val;
			if (wr_b6) bank6_q[reg_s1[sbsmi_pkg::BANK6_AW-1:0]] <= wr_val;
			// trap hit with both enables: flag status and catch the data
			if (trap_set) begin
				bank6_q[sbsmi_pkg::B6_SMI_STAT] <= sbsmi_pkg::SMI_STAT_SET;
				trap_latch_q <= data_s1;
			end
			for (int i = 0; i < sbsmi_pkg::NUM_INT; i++) route_q[i] <= route_next[i];
		end
	end

	// input register control; an empty input register takes a request
	// even while the result is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1 <= sbsmi_pkg::mode_t'(mode);
			func_s1 <= function_number;
			reg_s1  <= reg_addr;
			io_s1   <= io_addr;
			data_s1 <= data;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			read_data_q <= rd_next;
			trap_hit_q  <= hit_next;
			smi_q       <= trap_set;
			for (int i = 0; i < sbsmi_pkg::NUM_INT; i++) irq_q[i] <= route_next[i];
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign trap_hit    = trap_hit_q;
	assign smi_request = smi_q;
	assign inta_irq    = irq_q[0];
	assign intb_irq    = irq_q[1];
	assign intc_irq    = irq_q[2];
	assign intd_irq    = irq_q[3];

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// tb_top: self-checking bench for the southbridge config space with smi trap port
// drives random and directed bus requests, predicts every reply in the bench itself
// depends on sbsmi_pkg and southbridge_smi_trap_regs_top
`timescale 1ns / 1ps

module tb_top;
	import sbsmi_pkg::*;

	localparam int CLK_HALF_NS      = 2;
	localparam int RESET_CYCLES     = 6;
	localparam int DRAIN_CYCLES     = 8;     // two pipeline stages, with margin
	localparam int WATCHDOG_LIMIT   = 2000;  // quiet cycles before giving up
	localparam int RANDOM_TARGET    = 1600;  // random requests over all phases
	localparam int NUM_RANDOM_PHASES = 6;
	localparam int REPORT_MAX       = 10;
	localparam int LONG_HOLD_AT     = 200;   // reply count that triggers the long hold
	localparam int LONG_HOLD_CYCLES = 120;

	// config space offsets used by the bench beyond the ones the package names
	localparam logic [7:0] OFS_UNLISTED  = 8'h10;
	localparam logic [7:0] OFS_SMI_EN    = 8'h60;
	localparam logic [7:0] OFS_TRAP_STAT = 8'h61;
	localparam logic [7:0] OFS_PORT_HI   = 8'h62;
	localparam logic [7:0] OFS_PORT_LO   = 8'h63;
	localparam logic [7:0] OFS_GLOBAL_EN = 8'h6D;
	localparam logic [7:0] OFS_JUMPER    = 8'h73;

	// one bus request as the sender offers it
	typedef struct packed {
		mode_t       mode;
		logic [2:0]  fn;
		logic [7:0]  offset;
		logic [15:0] io;
		logic [7:0]  wdata;
	} access_t;

	// one reply, in port order
	typedef struct packed {
		logic [7:0] rdata;
		logic       hit;
		logic       smi;
		logic [3:0] irq_a;
		logic [3:0] irq_b;
		logic [3:0] irq_c;
		logic [3:0] irq_d;
	} reply_t;

	// dut ports; the inputs are all known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic        cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = '0;
	logic [2:0]  function_number = '0;
	logic [7:0]  reg_addr = '0;
	logic [15:0] io_addr = '0;
	logic [7:0]  data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  read_data;
	logic        trap_hit;
	logic        smi_request;
	logic [3:0]  inta_irq;
	logic [3:0]  intb_irq;
	logic [3:0]  intc_irq;
	logic [3:0]  intd_irq;

	// bench copy of the block state and its settings
	logic [7:0] shadow_regs [256];
	logic [7:0] shadow_trap;
	logic [3:0] shadow_route [4];
	logic       variant_q;
	logic       readout_q;
	logic       fast_q;
	logic       lowmul_q;
	logic [3:0] route_irq [8] = '{4'd3, 4'd5, 4'd9, 4'd10, 4'd11, 4'd12, 4'd14, 4'd15};

	access_t pending_accesses [$];
	reply_t  expected_replies [$];

	// driver state
	access_t     offered;
	reply_t      predicted;
	int unsigned send_gap = 0;
	int unsigned sent_count = 0;

	// monitor state
	reply_t      want;
	reply_t      got;
	int unsigned replies_seen = 0;
	int unsigned hold_cycles = 0;
	int unsigned mismatches = 0;

	int unsigned quiet_cycles = 0;

	southbridge_smi_trap_regs_top u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_idx         (cfg_idx),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.function_number (function_number),
		.reg_addr        (reg_addr),
		.io_addr         (io_addr),
		.data            (data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.read_data       (read_data),
		.trap_hit        (trap_hit),
		.smi_request     (smi_request),
		.inta_irq        (inta_irq),
		.intb_irq        (intb_irq),
		.intc_irq        (intc_irq),
		.intd_irq        (intd_irq)
	);

	always #(CLK_HALF_NS) clk = ~clk;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// offsets that keep the written byte
	function automatic bit stores_byte(input logic [7:0] o);
		return (o >= 8'h04 && o <= 8'h05) || (o >= 8'h50 && o <= 8'h5A) ||
			(o >= 8'h5C && o <= 8'h5D) || o == 8'h60 || (o >= 8'h62 && o <= 8'h64) ||
			o == 8'h66 || o == 8'h68 || (o >= 8'h6B && o <= 8'h78);
	endfunction

	// status bytes that any write clears
	function automatic bit clears_on_write(input logic [7:0] o);
		return o == 8'h61 || o == 8'h65 || o == 8'h67 || o == 8'h69;
	endfunction

	// stored byte, with the speed jumpers merged into the smi status read
	function automatic logic [7:0] config_readback(input logic [7:0] o);
		logic [7:0] v;
		v = shadow_regs[o];
		if (o == REG_SMI_STAT && readout_q &&
				(shadow_regs[OFS_JUMPER] & JUMPER_MASK) != 8'h00) begin
			v[2] = 1'b1;
			v[1] = fast_q;
			v[0] = lowmul_q;
		end
		return v;
	endfunction

	// apply one request to the bench state and work out its reply
	task automatic predict_access(input access_t a, output reply_t r);
		logic [15:0] port;
		logic        match;
		r = '0;
		port = {shadow_regs[OFS_PORT_HI], shadow_regs[OFS_PORT_LO]};
		match = (port != 16'h0000) && (a.io == port);
		case (a.mode)
			MODE_CFG_RD: begin
				r.rdata = (a.fn == 3'd0) ? config_readback(a.offset) : BYTE_ONES;
			end
			MODE_CFG_WR: begin
				if (a.fn == 3'd0) begin
					if (stores_byte(a.offset))
						shadow_regs[a.offset] = a.wdata;
					else if (clears_on_write(a.offset))
						shadow_regs[a.offset] = 8'h00;
					else if (a.offset == REG_NIBBLE)
						shadow_regs[a.offset] = a.wdata & NIBBLE_MASK;
					if (a.offset == REG_ROUTE_AB) begin
						shadow_route[0] = route_irq[a.wdata[2:0]];
						shadow_route[1] = route_irq[a.wdata[6:4]];
					end else if (a.offset == REG_ROUTE_CD) begin
						shadow_route[2] = route_irq[a.wdata[2:0]];
						shadow_route[3] = route_irq[a.wdata[6:4]];
					end
				end
			end
			MODE_TRAP_RD: begin
				r.hit = match;
				r.rdata = match ? shadow_trap : BYTE_ONES;
			end
			default: begin
				r.hit = match;
				if (match && shadow_regs[OFS_GLOBAL_EN][EN_BIT] &&
						shadow_regs[OFS_SMI_EN][EN_BIT]) begin
					shadow_regs[OFS_TRAP_STAT] = SMI_STAT_SET;
					shadow_trap = a.wdata;
					r.smi = 1'b1;
				end
			end
		endcase
		r.irq_a = shadow_route[0];
		r.irq_b = shadow_route[1];
		r.irq_c = shadow_route[2];
		r.irq_d = shadow_route[3];
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic access_t make_access(input mode_t m, input logic [2:0] f,
		input logic [7:0] o, input logic [15:0] io, input logic [7:0] d);
		access_t a;
		a.mode = m;
		a.fn = f;
		a.offset = o;
		a.io = io;
		a.wdata = d;
		return a;
	endfunction

	// idle length from three ranges: mostly the shortest, now and then the longest
	function automatic int unsigned gap_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		else if (r < 94)
			return $urandom_range(3, 8);
		else
			return $urandom_range(20, 60);
	endfunction

	// offsets weighted toward the smi and routing bank and the identity bytes
	function automatic logic [7:0] hot_offset();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 8'($urandom_range(8'h5E, 8'h79));
		else if (r < 6)
			return 8'($urandom_range(8'h00, 8'h0B));
		else
			return 8'($urandom);
	endfunction

	// random request; trap accesses mostly aim at the port the bench expects to be programmed
	function automatic access_t random_access(input logic [15:0] port_guess);
		access_t     a;
		int unsigned pick;
		a.mode = MODE_CFG_RD;
		a.fn = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
		a.offset = 8'($urandom);
		a.io = 16'($urandom);
		a.wdata = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			a.offset = hot_offset();
		end else if (pick < 40) begin
			a.mode = MODE_CFG_WR;
			a.offset = hot_offset();
			if (a.offset == OFS_SMI_EN || a.offset == OFS_GLOBAL_EN)
				a.wdata[EN_BIT] = ($urandom_range(0, 3) != 0);
		end else if (pick < 50) begin
			// reprogram the trap port a byte at a time, now and then to zero
			a.mode = MODE_CFG_WR;
			a.fn = 3'd0;
			a.offset = $urandom_range(0, 1) ? OFS_PORT_HI : OFS_PORT_LO;
			if ($urandom_range(0, 7) == 0)
				a.wdata = 8'h00;
		end else begin
			a.mode = (pick < 80) ? MODE_TRAP_WR : MODE_TRAP_RD;
			if ($urandom_range(0, 3) != 0)
				a.io = port_guess;
		end
		return a;
	endfunction

	// write all four settings while the block is idle, then mirror them
	// bits: 0 chip variant, 1 speed readout, 2 fast bus, 3 low multiplier
	task automatic apply_settings(input logic [3:0] s);
		cfg_idx_t idx;
		for (int i = 0; i < 4; i++) begin
			idx = cfg_idx_t'(i);
			@(posedge clk);
			cfg_wen <= 1'b1;
			cfg_idx <= idx;
			cfg_data <= s[i];
			@(posedge clk);
			cfg_wen <= 1'b0;
			case (idx)
				CFG_CHIP_VARIANT: begin
					variant_q = s[i];
					shadow_regs[REG_DEV_ID] = s[i] ? DEV_ID_B : DEV_ID_A;
				end
				CFG_SPEED_READOUT:  readout_q = s[i];
				CFG_FAST_BUS:       fast_q = s[i];
				CFG_LOW_MULTIPLIER: lowmul_q = s[i];
			endcase
		end
		@(negedge clk);
	endtask

	// everything offered, accepted and answered, plus a margin of DRAIN_CYCLES
	task automatic wait_drained();
		@(negedge clk);
		while (pending_accesses.size() != 0 || in_valid || expected_replies.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// sequence of phases
	// ------------------------------------------------------------------
	initial begin
		access_t     a;
		logic [15:0] port_guess;
		int unsigned queued;
		logic [3:0]  setting;

		// bench state after reset
		foreach (shadow_regs[i])
			shadow_regs[i] = 8'h00;
		shadow_regs[REG_VENDOR_LO] = VENDOR_LO;
		shadow_regs[REG_VENDOR_HI] = VENDOR_HI;
		shadow_regs[REG_DEV_ID]    = DEV_ID_A;
		shadow_regs[REG_SUBCLASS]  = SUBCLASS;
		shadow_regs[REG_BASECLASS] = BASECLASS;
		shadow_trap = 8'h00;
		foreach (shadow_route[i])
			shadow_route[i] = 4'd0;
		variant_q = 1'b0;
		readout_q = 1'b0;
		fast_q = 1'b0;
		lowmul_q = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset settings: identity bytes, dead function, dead offset
		pending_accesses.push_back(make_access(MODE_CFG_RD, 3'd0, REG_VENDOR_LO, 16'h0000, 8'h00));
		pending_accesses.push_back(make_access(MODE_CFG_RD, 3'd0, REG_DEV_ID, 16'hFFFF, 8'hFF));
		pending_accesses.push_back(make_access(MODE_CFG_RD, 3'd7, 8'hFF, 16'h0000, 8'h00));
		pending_accesses.push_back(make_access(MODE_CFG_WR, 3'd7, OFS_SMI_EN, 16'h0000, 8'hFF));
		pending_accesses.push_back(make_access(MODE_CFG_WR, 3'd0, OFS_UNLISTED, 16'h0000, 8'hAA));
		// trap port still zero: io 0 must not match
		pending_accesses.push_back(make_access(MODE_TRAP_RD, 3'd0, 8'h00, 16'h0000, 8'h00));
		pending_accesses.push_back(make_access(MODE_CFG_WR, 3'd0, OFS_PORT_HI, 16'h0000, 8'h12));
		pending_accesses.push_back(make_access(MODE_CFG_WR, 3'd0, OFS_PORT_LO, 16'h0000, 8'h34));
		// hit with smi disabled: flagged, nothing latched
		pending_accesses.push_back(make_access(MODE_TRAP_WR, 3'd0, 8'h00, 16'h1234, 8'h5A));
		pending_accesses.push_back(make_access(MODE_CFG_WR, 3'd0, OFS_SMI_EN, 16'h0000, 8'h80));
		pending_accesses.push_back(make_access(MODE_CFG_WR, 3'd0, OFS_GLOBAL_EN, 16'h0000, 8'hFF));
		pending_accesses.push_back(make_access(MODE_TRAP_WR, 3'd0, 8'h00, 16'h1234, 8'hA5));
		pending_accesses.push_back(make_access(MODE_TRAP_RD, 3'd0, 8'h00, 16'h1235, 8'h00));
		pending_accesses.push_back(make_access(MODE_TRAP_RD, 3'd0, 8'h00, 16'h1234, 8'h00));
		// trap status set by the smi, then cleared by any write
		pending_accesses.push_back(make_access(MODE_CFG_RD, 3'd0, OFS_TRAP_STAT, 16'h0000, 8'h00));
		pending_accesses.push_back(make_access(MODE_CFG_WR, 3'd0, OFS_TRAP_STAT, 16'h0000, 8'hFF));
		pending_accesses.push_back(make_access(MODE_CFG_RD, 3'd0, OFS_TRAP_STAT, 16'h0000, 8'h00));
		pending_accesses.push_back(make_access(MODE_CFG_WR, 3'd0, REG_NIBBLE, 16'h0000, 8'hFF));
		pending_accesses.push_back(make_access(MODE_CFG_RD, 3'd0, REG_NIBBLE, 16'h0000, 8'h00));
		// routing with the unused bits 3 and 7 set
		pending_accesses.push_back(make_access(MODE_CFG_WR, 3'd0, REG_ROUTE_AB, 16'h0000, 8'hF8));
		pending_accesses.push_back(make_access(MODE_CFG_WR, 3'd0, REG_ROUTE_CD, 16'h0000, 8'h8F));
		// device id is read only
		pending_accesses.push_back(make_access(MODE_CFG_WR, 3'd0, REG_DEV_ID, 16'h0000, 8'hFF));
		wait_drained();

		// second variant with the speed readout on
		apply_settings(4'b0111);
		pending_accesses.push_back(make_access(MODE_CFG_RD, 3'd0, REG_DEV_ID, 16'h0000, 8'h00));
		pending_accesses.push_back(make_access(MODE_CFG_RD, 3'd0, REG_SMI_STAT, 16'h0000, 8'h00));
		pending_accesses.push_back(make_access(MODE_CFG_WR, 3'd0, OFS_JUMPER, 16'h0000, 8'h2A));
		pending_accesses.push_back(make_access(MODE_CFG_RD, 3'd0, REG_SMI_STAT, 16'h0000, 8'h00));
		pending_accesses.push_back(make_access(MODE_CFG_WR, 3'd0, REG_SMI_STAT, 16'h0000, 8'hFF));
		wait_drained();

		apply_settings(4'b1011);
		pending_accesses.push_back(make_access(MODE_CFG_RD, 3'd0, REG_SMI_STAT, 16'h0000, 8'h00));
		pending_accesses.push_back(make_access(MODE_TRAP_WR, 3'd0, 8'h00, 16'hFFFF, 8'h00));
		wait_drained();

		// random phases: all settings low, all high, then random ones
		for (int p = 0; p < NUM_RANDOM_PHASES; p++) begin
			if (p == 0)
				setting = 4'h0;
			else if (p == 1)
				setting = 4'hF;
			else
				setting = 4'($urandom);
			apply_settings(setting);
			// the block is idle here, so the bench copy of the port is exact
			port_guess = {shadow_regs[OFS_PORT_HI], shadow_regs[OFS_PORT_LO]};
			queued = 0;
			while (queued < RANDOM_TARGET / NUM_RANDOM_PHASES) begin
				a = random_access(port_guess);
				queued++;
				if (a.mode == MODE_CFG_WR && a.fn == 3'd0 && a.offset == OFS_PORT_HI)
					port_guess[15:8] = a.wdata;
				if (a.mode == MODE_CFG_WR && a.fn == 3'd0 && a.offset == OFS_PORT_LO)
					port_guess[7:0] = a.wdata;
				pending_accesses.push_back(a);
			end
			wait_drained();
		end

		if (mismatches == 0 && expected_replies.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// driver: offers queued requests, predicts each one as it is taken
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_access(offered, predicted);
				expected_replies.push_back(predicted);
				sent_count++;
				// the first quarter of every 256 requests go back to back, the rest only at random
				if ((sent_count % 256) < 64 || $urandom_range(0, 99) < 55)
					send_gap = 0;
				else
					send_gap = gap_length();
			end
			// a stalled request stays on the bus untouched
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_accesses.size() != 0) begin
					offered = pending_accesses.pop_front();
					in_valid <= 1'b1;
					mode <= offered.mode;
					function_number <= offered.fn;
					reg_addr <= offered.offset;
					io_addr <= offered.io;
					data <= offered.wdata;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: checks replies in order and throttles the result side
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{read_data, trap_hit, smi_request, inta_irq, intb_irq, intc_irq,
					intd_irq};
				if (expected_replies.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display({"reply with no request outstanding: ",
							"rd=%h hit=%b smi=%b irq=%h/%h/%h/%h"},
							got.rdata, got.hit, got.smi, got.irq_a, got.irq_b,
							got.irq_c, got.irq_d);
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					if (got !== want) begin
						if (mismatches < REPORT_MAX)
							$display({"reply %0d mismatch: rd %h/%h hit %b/%b smi %b/%b ",
								"irq %h%h%h%h/%h%h%h%h (exp/act)"},
								replies_seen, want.rdata, got.rdata, want.hit, got.hit,
								want.smi, got.smi,
								want.irq_a, want.irq_b, want.irq_c, want.irq_d,
								got.irq_a, got.irq_b, got.irq_c, got.irq_d);
						mismatches++;
					end
				end
				replies_seen++;
				// one long hold so the block backs up into the request side
				if (replies_seen == LONG_HOLD_AT)
					hold_cycles = LONG_HOLD_CYCLES;
			end
			if (hold_cycles != 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else if ((replies_seen % 256) >= 128 && (replies_seen % 256) < 192) begin
				// stretch with the result side always ready
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 99) < 25) begin
				hold_cycles = gap_length() - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too long without any request or reply moving
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule
